// ===== rtl/core/rectangle_zone_hit_tester_core_macros.svh =====
// Assertion macros used by the rectangle zone hit tester core.
`ifndef RECTANGLE_ZONE_HIT_TESTER_CORE_MACROS_SVH
`define RECTANGLE_ZONE_HIT_TESTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RZHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RZHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rzht_pkg.sv =====
// Types and constants of the rectangle zone hit tester.
`timescale 1ns / 1ps
package rzht_pkg;

    localparam int COORD_W  = 16;
    localparam int KIND_W   = 4;
    localparam int TAG_W    = 16;
    localparam int OFS_W    = 15;
    localparam int FUNC_W   = 2;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 56;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_TEST  = 2'd2
    } func_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] h;
        logic [KIND_W-1:0]         kind;
        logic [TAG_W-1:0]          tag;
    } zone_t;

    // Request travelling down the chain of cells.
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      found;
        logic [KIND_W-1:0]         kind;
        logic [TAG_W-1:0]          tag;
        logic [OFS_W-1:0]          ofs_x;
        logic [OFS_W-1:0]          ofs_y;
    } tok_t;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] hit_kind;
        logic [TAG_W-1:0]  hit_tag;
        logic [OFS_W-1:0]  offset_x;
        logic [OFS_W-1:0]  offset_y;
        logic              added;
    } result_t;

endpackage

// ===== rtl/core/rzht_cell.sv =====
// One zone slot of the chain: holds a rectangle and tests the passing request.
`timescale 1ns / 1ps
module rzht_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  rzht_pkg::zone_t wr_zone,
    input  logic            active,
    input  logic            tok_in_valid,
    input  rzht_pkg::tok_t  tok_in,
    output logic            tok_out_valid,
    output rzht_pkg::tok_t  tok_out
);
    import rzht_pkg::*;

    zone_t zone_reg;
    logic  valid_reg;
    tok_t  tok_reg;
    tok_t  tok_next;

    logic signed [COORD_W:0] px17, py17, zx17, zy17, xe17, ye17, dx17, dy17;
    logic                    match;

    always_comb begin
        px17 = {tok_in.px[COORD_W-1], tok_in.px};
        py17 = {tok_in.py[COORD_W-1], tok_in.py};
        zx17 = {zone_reg.x[COORD_W-1], zone_reg.x};
        zy17 = {zone_reg.y[COORD_W-1], zone_reg.y};
        xe17 = zx17 + {zone_reg.w[COORD_W-1], zone_reg.w};
        ye17 = zy17 + {zone_reg.h[COORD_W-1], zone_reg.h};
        dx17 = px17 - zx17;
        dy17 = py17 - zy17;
        match = active && (px17 >= zx17) && (px17 < xe17)
                && (py17 >= zy17) && (py17 < ye17);
        tok_next = tok_in;
        if (!tok_in.found && match) begin
            tok_next.found = 1'b1;
            tok_next.kind  = zone_reg.kind;
            tok_next.tag   = zone_reg.tag;
            tok_next.ofs_x = dx17[OFS_W-1:0];
            tok_next.ofs_y = dy17[OFS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            zone_reg <= wr_zone;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    assign tok_out_valid = valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ===== rtl/core/rectangle_zone_hit_tester_core.sv =====
// Top level of the rectangle zone hit tester: control, zone count and cell chain.
`timescale 1ns / 1ps
`include "rectangle_zone_hit_tester_core_macros.svh"
// Usage:
//   Input stream s_*: one request per handshake (s_tvalid && s_tready).
//   s_tuser carries the operation: clear, add zone or test point.
//   Output stream m_*: exactly one result per request, in request order.
//   Clear and add set the pending result at the accept; ST_DONE then
//   loads it into the output register that drives m_tvalid.
//   A test walks the point down a chain of MAX_ZONES cells, one cell per
//   cycle, and the chain exit loads the pending result as ST_DONE begins.
//   One request is in work at a time: s_tready is high only while idle,
//   so a new request is taken only once the previous one has left ST_DONE.
//   The result register frees the input side: a new request is taken
//   while the previous result still waits on m_tready.
//   When the receiver stalls, the finished result waits in an internal
//   register and the block holds until the output register frees.
//   The first zone in insertion order that contains the point wins.
//   Reset (aresetn low, synchronous) empties the table and drops any
//   request in flight; zone contents need no clearing since slots at or
//   above the zone count are never consulted.
module rectangle_zone_hit_tester_core #(
    parameter int MAX_ZONES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] zone_width, [63:48] zone_height,
    // [67:64] zone_kind, [83:68] zone_tag, [87:84] zero
    input  logic [rzht_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [rzht_pkg::FUNC_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] hit, [4:1] hit_kind, [20:5] hit_tag, [35:21] offset_x,
    // [50:36] offset_y, [51] added, [55:52] zero
    output logic [rzht_pkg::M_DATA_W-1:0] m_tdata
);
    import rzht_pkg::*;

    localparam int CNT_W = $clog2(MAX_ZONES + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   zones_used_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               m_valid_reg;
    result_t            m_data_reg;

    logic               s_accept, out_free, inject, load_out;
    logic               not_full;
    func_e_t            func;
    zone_t              new_zone;
    tok_t               tok_first;

    logic [MAX_ZONES:0] chain_valid;
    tok_t               chain_tok [MAX_ZONES+1];

    assign func     = func_e_t'(s_tuser);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign not_full = zones_used_reg < CNT_W'(MAX_ZONES);

    // Payload unpacking
    always_comb begin
        new_zone.x    = s_tdata[15:0];
        new_zone.y    = s_tdata[31:16];
        new_zone.w    = s_tdata[47:32];
        new_zone.h    = s_tdata[63:48];
        new_zone.kind = s_tdata[67:64];
        new_zone.tag  = s_tdata[83:68];
        tok_first       = '0;
        tok_first.px    = new_zone.x;
        tok_first.py    = new_zone.y;
    end

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (func == FUNC_TEST) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (chain_valid[MAX_ZONES]) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_WALK: s_tready = 1'b0;
            ST_DONE: load_out = out_free;
            default: s_tready = 1'b0;
        endcase
    end

    assign inject = s_accept && (func == FUNC_TEST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            zones_used_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (s_accept && func == FUNC_CLEAR) begin
                zones_used_reg <= '0;
            end else if (s_accept && func == FUNC_ADD && not_full) begin
                zones_used_reg <= zones_used_reg + CNT_W'(1);
            end
        end
    end

    // Pending result: set at accept for non-tests, at chain exit for tests
    always_comb begin
        res_next = res_reg;
        if (s_accept) begin
            res_next       = '0;
            res_next.added = (func == FUNC_ADD) && not_full;
        end else if (chain_valid[MAX_ZONES]) begin
            res_next.hit      = chain_tok[MAX_ZONES].found;
            res_next.hit_kind = chain_tok[MAX_ZONES].kind;
            res_next.hit_tag  = chain_tok[MAX_ZONES].tag;
            res_next.offset_x = chain_tok[MAX_ZONES].ofs_x;
            res_next.offset_y = chain_tok[MAX_ZONES].ofs_y;
            res_next.added    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_data_reg.added, m_data_reg.offset_y, m_data_reg.offset_x,
                       m_data_reg.hit_tag, m_data_reg.hit_kind, m_data_reg.hit};

    // Cell chain; slot i holds the i-th added zone
    assign chain_valid[0] = inject;
    assign chain_tok[0]   = tok_first;

    for (genvar i = 0; i < MAX_ZONES; i++) begin : g_cell
        rzht_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .wr_en         (s_accept && func == FUNC_ADD
                            && zones_used_reg == CNT_W'(i)),
            .wr_zone       (new_zone),
            .active        (zones_used_reg > CNT_W'(i)),
            .tok_in_valid  (chain_valid[i]),
            .tok_in        (chain_tok[i]),
            .tok_out_valid (chain_valid[i+1]),
            .tok_out       (chain_tok[i+1])
        );
    end

    `RZHT_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, zones_used_reg <= CNT_W'(MAX_ZONES), "zone count above capacity")
    `RZHT_ASSERT_NOW(a_exit_in_walk, aclk, aresetn, chain_valid[MAX_ZONES], state_reg == ST_WALK, "chain exit outside walk")
    `RZHT_ASSERT_NEXT(a_test_walks, aclk, aresetn, s_accept && func == FUNC_TEST, state_reg == ST_WALK, "test did not start walk")
    `RZHT_ASSERT_NEXT(a_add_counts, aclk, aresetn, s_accept && func == FUNC_ADD && not_full, zones_used_reg == $past(zones_used_reg) + CNT_W'(1), "add did not bump count")

endmodule
